### rtl/adr_pkg.sv
// adr_pkg: shared types, codes and constants of the dead reckoning block
// used by accel_dead_reckoning; no dependencies
`default_nettype none

package adr_pkg;

  // default parameter values
  localparam int ACCUM_WIDTH_DEFAULT = 48;
  localparam int FRAC_BITS_DEFAULT   = 24;

  // fixed field widths
  localparam int ACCEL_W    = 16;
  localparam int DT_W       = 16;
  localparam int POS_W      = 48;
  localparam int CODE_W     = 3;
  localparam int VEL_W      = 40;
  localparam int VEL_FRAC   = 24;
  localparam int SUM_W      = VEL_W + 1;
  localparam int PROD_W     = SUM_W + DT_W + 1;
  localparam int MUL_W      = 33;
  localparam int MULQ_W     = 2 * MUL_W;
  localparam int PHASE_W    = 3;

  // stream and config port widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_PAD_W  = OUT_DATA_W - 3 * POS_W - CODE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y         = 2'd2;

  localparam logic [DT_W-1:0] SAMPLE_INTERVAL_RESET = 16'd655;

  typedef enum logic {
    OP_ACCEL   = 1'b0,
    OP_HEADING = 1'b1
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    HDG_0     = 3'd0,
    HDG_90    = 3'd1,
    HDG_M90   = 3'd2,
    HDG_180   = 3'd3,
    HDG_OTHER = 3'd4
  } hdg_t;

  typedef enum logic [CODE_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_UP    = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_LEFT  = 3'd4
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEL,
    ST_STEP,
    ST_MAG,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_t;

  // what the product register holds this cycle
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_VEL_X,
    MOP_VEL_Y,
    MOP_STEP_X_LO,
    MOP_STEP_X_HI,
    MOP_STEP_Y_LO,
    MOP_STEP_Y_HI,
    MOP_SQ_LL,
    MOP_SQ_HL,
    MOP_SQ_HH
  } mul_op_t;

  // dominant direction for a heading, axis and sign
  function automatic dir_t dir_lookup(hdg_t h, logic y_axis, logic neg);
    dir_t d;
    d = DIR_NONE;
    case ({y_axis, neg})
      2'b00: begin
        case (h)
          HDG_0:   d = DIR_RIGHT;
          HDG_90:  d = DIR_UP;
          HDG_M90: d = DIR_DOWN;
          HDG_180: d = DIR_LEFT;
          default: d = DIR_NONE;
        endcase
      end
      2'b01: begin
        case (h)
          HDG_0:   d = DIR_LEFT;
          HDG_90:  d = DIR_DOWN;
          HDG_M90: d = DIR_UP;
          HDG_180: d = DIR_RIGHT;
          default: d = DIR_NONE;
        endcase
      end
      2'b10: begin
        case (h)
          HDG_0:   d = DIR_UP;
          HDG_90:  d = DIR_LEFT;
          HDG_M90: d = DIR_RIGHT;
          HDG_180: d = DIR_DOWN;
          default: d = DIR_NONE;
        endcase
      end
      default: begin
        case (h)
          HDG_0:   d = DIR_DOWN;
          HDG_90:  d = DIR_RIGHT;
          HDG_M90: d = DIR_LEFT;
          HDG_180: d = DIR_UP;
          default: d = DIR_NONE;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/adr_sqrt.sv
// adr_sqrt: iterative integer square root, one root bit per cycle
// standalone; used by accel_dead_reckoning for the path increment
`default_nettype none

module adr_sqrt #(
  parameter int ROOT_W = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic [ROOT_W-1:0]          root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] rem_t;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] rem_d;
  logic              ge;

  assign rem_t = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign rem_d = rem_t - trial;
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? rem_d[ROOT_W:0] : rem_t[ROOT_W:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/accel_dead_reckoning.sv
// accel_dead_reckoning: trapezoidal double integration of acceleration
// samples into path length, rotated position and dominant direction
// depends on adr_pkg and adr_sqrt
//
// input stream: s_tuser selects an acceleration sample or a heading update,
// s_tdata carries both acceleration samples and the heading code. every
// input beat gives exactly one output beat on m_tdata.
// config: cfg_we writes sample_interval, start_x or start_y by cfg_index;
// write only while no beat is in flight.
// timing: one shared 33x33 multiplier does the velocity, step and square
// products in sequence, then a one-bit-per-cycle square root runs. an
// acceleration beat passes through the velocity, step, magnitude, square,
// root and finish steps before the next accept; a heading beat goes
// straight to the finish step. m_tvalid is set as the finish step loads
// the output register, for either kind of beat.
// s_tready is high only while the sequencer is idle and rst is low. results
// sit in an output register, so a new beat is accepted while the last result
// waits; a finished result stalls in the final step until m_tready frees the
// register. rst clears velocity, displacement, path and heading and loads
// the config reset values.
`default_nettype none

module accel_dead_reckoning
  import adr_pkg::*;
#(
  parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEFAULT,
  parameter int FRAC_BITS   = FRAC_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // accel_x [15:0], accel_y [31:16], heading_code [34:32], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // path_length [47:0], position_x [95:48], position_y [143:96],
  // direction [146:144], zero pad
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int W          = ACCUM_WIDTH;
  localparam int HALF       = (W + 1) / 2;
  localparam int SQ_W       = 2 * W;
  localparam int STEP_SHIFT = VEL_FRAC + DT_W + 1 - FRAC_BITS;
  localparam int STEP_EXT   = (PROD_W > W) ? PROD_W : W;

  state_t               state, state_next;
  logic [PHASE_W-1:0]   phase, phase_next;

  // config
  logic [DT_W-1:0]          sample_interval;
  logic signed [POS_W-1:0]  start_x, start_y;

  // architectural state
  logic signed [VEL_W-1:0]  vel_x, vel_y;
  logic [W-1:0]             disp_x, disp_y;
  logic [W-1:0]             path_total;
  hdg_t                     heading;

  // work registers
  logic signed [ACCEL_W-1:0] acc_x_q, acc_y_q;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [PROD_W-1:0]  prod_acc;
  logic signed [W-1:0]       step_x, step_y;
  logic [W-1:0]              mag_x, mag_y;
  logic [SQ_W-1:0]           sq_acc;

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [MULQ_W-1:0]  mul_q;
  mul_op_t                   issue_op, mul_tag;

  logic                      root_start, root_done, out_load;
  logic [W-1:0]              root;

  // datapath around the product register
  logic signed [VEL_W-1:0]    vel_sel, vel_new;
  logic signed [SUM_W-1:0]    sum_new;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [STEP_EXT-1:0] prod_ext, prod_shr;
  logic signed [W-1:0]        step_new;
  logic [SQ_W-1:0]            sq_prod, sq_term;

  // result formation
  logic [W-1:0]  sx_w, sy_w, px, py, mdx, mdy;
  dir_t          dir_next;
  logic [CODE_W-1:0] heading_in;

  assign s_tready   = (state == ST_IDLE) && !rst;
  assign heading_in = s_tdata[34:32];

  adr_sqrt #(
    .ROOT_W (W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq_acc),
    .done     (root_done),
    .root     (root)
  );

  // sequencer
  always_comb begin
    state_next = state;
    phase_next = phase;
    issue_op   = MOP_NONE;
    mul_a      = '0;
    mul_b      = signed'(MUL_W'(sample_interval));
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        phase_next = '0;
        if (s_tvalid) begin
          state_next = (s_tuser == OP_HEADING) ? ST_FINISH : ST_VEL;
        end
      end
      ST_VEL: begin
        phase_next = phase + 1'b1;
        case (phase)
          3'd0: begin
            mul_a    = MUL_W'(acc_x_q);
            issue_op = MOP_VEL_X;
          end
          3'd1: begin
            mul_a    = MUL_W'(acc_y_q);
            issue_op = MOP_VEL_Y;
          end
          default: begin
            state_next = ST_STEP;
            phase_next = '0;
          end
        endcase
      end
      ST_STEP: begin
        phase_next = phase + 1'b1;
        case (phase)
          3'd0: begin
            mul_a    = signed'(MUL_W'(sum_x[VEL_FRAC-1:0]));
            issue_op = MOP_STEP_X_LO;
          end
          3'd1: begin
            mul_a    = MUL_W'(signed'(sum_x[SUM_W-1:VEL_FRAC]));
            issue_op = MOP_STEP_X_HI;
          end
          3'd2: begin
            mul_a    = signed'(MUL_W'(sum_y[VEL_FRAC-1:0]));
            issue_op = MOP_STEP_Y_LO;
          end
          3'd3: begin
            mul_a    = MUL_W'(signed'(sum_y[SUM_W-1:VEL_FRAC]));
            issue_op = MOP_STEP_Y_HI;
          end
          default: begin
            state_next = ST_MAG;
            phase_next = '0;
          end
        endcase
      end
      ST_MAG: begin
        state_next = ST_SQUARE;
        phase_next = '0;
      end
      ST_SQUARE: begin
        phase_next = phase + 1'b1;
        case (phase)
          3'd0: begin
            mul_a    = signed'(MUL_W'(mag_x[HALF-1:0]));
            mul_b    = signed'(MUL_W'(mag_x[HALF-1:0]));
            issue_op = MOP_SQ_LL;
          end
          3'd1: begin
            mul_a    = signed'(MUL_W'(mag_x[W-1:HALF]));
            mul_b    = signed'(MUL_W'(mag_x[HALF-1:0]));
            issue_op = MOP_SQ_HL;
          end
          3'd2: begin
            mul_a    = signed'(MUL_W'(mag_x[W-1:HALF]));
            mul_b    = signed'(MUL_W'(mag_x[W-1:HALF]));
            issue_op = MOP_SQ_HH;
          end
          3'd3: begin
            mul_a    = signed'(MUL_W'(mag_y[HALF-1:0]));
            mul_b    = signed'(MUL_W'(mag_y[HALF-1:0]));
            issue_op = MOP_SQ_LL;
          end
          3'd4: begin
            mul_a    = signed'(MUL_W'(mag_y[W-1:HALF]));
            mul_b    = signed'(MUL_W'(mag_y[HALF-1:0]));
            issue_op = MOP_SQ_HL;
          end
          3'd5: begin
            mul_a    = signed'(MUL_W'(mag_y[W-1:HALF]));
            mul_b    = signed'(MUL_W'(mag_y[W-1:HALF]));
            issue_op = MOP_SQ_HH;
          end
          default: begin
            state_next = ST_ROOT;
            phase_next = '0;
          end
        endcase
      end
      ST_ROOT: begin
        if (phase == '0) begin
          root_start = 1'b1;
          phase_next = 3'd1;
        end else if (root_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // consumers of the product register
  always_comb begin
    vel_sel   = (mul_tag == MOP_VEL_Y) ? vel_y : vel_x;
    vel_new   = vel_sel + VEL_W'(mul_q);
    sum_new   = SUM_W'(vel_sel) + SUM_W'(vel_new);
    prod_full = prod_acc + (PROD_W'(mul_q) <<< VEL_FRAC);
    prod_ext  = STEP_EXT'(prod_full);
    prod_shr  = prod_ext >>> STEP_SHIFT;
    step_new  = prod_shr[W-1:0];
    sq_prod   = SQ_W'(unsigned'(mul_q));
    case (mul_tag)
      MOP_SQ_HL: sq_term = sq_prod << (HALF + 1);
      MOP_SQ_HH: sq_term = sq_prod << (2 * HALF);
      default:   sq_term = sq_prod;
    endcase
  end

  // position and dominant direction
  always_comb begin
    sx_w = W'(start_x);
    sy_w = W'(start_y);
    case (heading)
      HDG_0: begin
        px = sx_w + disp_x;
        py = sy_w + disp_y;
      end
      HDG_90: begin
        px = sx_w - disp_y;
        py = sy_w + disp_x;
      end
      HDG_M90: begin
        px = sx_w + disp_y;
        py = sy_w - disp_x;
      end
      HDG_180: begin
        px = sx_w - disp_x;
        py = sy_w - disp_y;
      end
      default: begin
        px = sx_w;
        py = sy_w;
      end
    endcase
    mdx = disp_x[W-1] ? -disp_x : disp_x;
    mdy = disp_y[W-1] ? -disp_y : disp_y;
    if (heading == HDG_OTHER) begin
      dir_next = DIR_NONE;
    end else if (mdx > mdy) begin
      dir_next = dir_lookup(heading, 1'b0, disp_x[W-1]);
    end else if (mdy != '0) begin
      dir_next = dir_lookup(heading, 1'b1, disp_y[W-1]);
    end else begin
      dir_next = DIR_NONE;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= '0;
      mul_tag         <= MOP_NONE;
      sample_interval <= SAMPLE_INTERVAL_RESET;
      start_x         <= '0;
      start_y         <= '0;
      vel_x           <= '0;
      vel_y           <= '0;
      disp_x          <= '0;
      disp_y          <= '0;
      path_total      <= '0;
      heading         <= HDG_0;
      m_tvalid        <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      mul_tag <= issue_op;
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[DT_W-1:0];
          REG_START_X:         start_x <= cfg_data;
          REG_START_Y:         start_y <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready && s_tuser == OP_HEADING) begin
        heading <= (heading_in > HDG_OTHER) ? HDG_OTHER : hdg_t'(heading_in);
      end
      case (mul_tag)
        MOP_VEL_X: vel_x <= vel_new;
        MOP_VEL_Y: vel_y <= vel_new;
        default: ;
      endcase
      if (state == ST_MAG) begin
        disp_x <= disp_x + step_x;
        disp_y <= disp_y + step_y;
      end
      if (state == ST_ROOT && root_done) begin
        path_total <= path_total + root;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // work registers and output beat
  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
    if (s_tvalid && s_tready) begin
      acc_x_q <= s_tdata[15:0];
      acc_y_q <= s_tdata[31:16];
    end
    case (mul_tag)
      MOP_VEL_X:     sum_x <= sum_new;
      MOP_VEL_Y:     sum_y <= sum_new;
      MOP_STEP_X_LO: prod_acc <= PROD_W'(mul_q);
      MOP_STEP_Y_LO: prod_acc <= PROD_W'(mul_q);
      MOP_STEP_X_HI: step_x <= step_new;
      MOP_STEP_Y_HI: step_y <= step_new;
      MOP_SQ_LL:     sq_acc <= sq_acc + sq_term;
      MOP_SQ_HL:     sq_acc <= sq_acc + sq_term;
      MOP_SQ_HH:     sq_acc <= sq_acc + sq_term;
      default: ;
    endcase
    if (state == ST_MAG) begin
      mag_x  <= step_x[W-1] ? -step_x : step_x;
      mag_y  <= step_y[W-1] ? -step_y : step_y;
      sq_acc <= '0;
    end
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, dir_next, POS_W'(py), POS_W'(px),
                  POS_W'(path_total)};
    end
  end

`ifndef NO_ASSERTIONS
  a_root_in_root_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("root finished outside the root step");

  a_accel_starts_vel: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_ACCEL) |=> (state == ST_VEL && phase == '0))
    else $error("acceleration beat did not start the velocity step");

  a_heading_keeps_motion: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_HEADING) |=>
      ($stable(vel_x) && $stable(vel_y) && $stable(disp_x) && $stable(path_total)))
    else $error("heading beat changed motion state");

  a_square_in_square_state: assert property (@(posedge clk) disable iff (rst)
    (mul_tag == MOP_SQ_LL || mul_tag == MOP_SQ_HL || mul_tag == MOP_SQ_HH)
      |-> state == ST_SQUARE)
    else $error("square product consumed outside the square step");
`endif

endmodule

`default_nettype wire
